/* rtl/pnp_rdp_pkg.sv */
// Shared types, constants and record decode for the resource descriptor parser.
// Used by rtl/pnp_resource_descriptor_parser.sv; no dependencies.
`default_nettype none

package pnp_rdp_pkg;

   localparam int CAPTURE_BYTES_DEF = 9;
   localparam int DECODE_BYTES      = 9;

   localparam logic [7:0] LETTER_BASE    = 8'h40;
   localparam logic [6:0] SMALL_END_NAME = 7'h0F;

   typedef enum logic [2:0] {
      PH_TAG,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_BODY,
      PH_DONE
   } phase_type;

   typedef enum logic [4:0] {
      KIND_VERSION      = 5'd0,
      KIND_LOGICAL_ID   = 5'd1,
      KIND_COMPAT_ID    = 5'd2,
      KIND_IRQ          = 5'd3,
      KIND_DMA          = 5'd4,
      KIND_IO           = 5'd5,
      KIND_FIXED_IO     = 5'd6,
      KIND_VENDOR_SMALL = 5'd7,
      KIND_RSVD_SMALL   = 5'd8,
      KIND_END          = 5'd9,
      KIND_MEM24        = 5'd10,
      KIND_ANSI         = 5'd11,
      KIND_UNICODE      = 5'd12,
      KIND_VENDOR_LARGE = 5'd13,
      KIND_MEM32        = 5'd14,
      KIND_FIXED_MEM32  = 5'd15,
      KIND_RSVD_LARGE   = 5'd16
   } kind_type;

   typedef logic [7:0] body_type [DECODE_BYTES];

   typedef struct packed {
      kind_type    item_kind;
      logic [31:0] first_value;
      logic [31:0] second_value;
      logic [7:0]  io_alignment;
      logic [7:0]  io_range_length;
      logic        full_decode;
      logic [15:0] body_length;
   } record_type;

   function automatic logic [7:0] letter(input logic [4:0] code);
      return LETTER_BASE + {3'b000, code};
   endfunction

   function automatic record_type decode_record(input logic       is_large,
                                                input logic [6:0] name,
                                                input body_type   body,
                                                input logic [15:0] length);
      record_type  rec;
      logic [15:0] packed_id;
      logic [31:0] start;
      logic [31:0] size;
      rec             = '0;
      rec.body_length = length;
      packed_id       = {body[0], body[1]};
      start           = {body[4], body[3], body[2], body[1]};
      size            = {body[8], body[7], body[6], body[5]};
      if (!is_large) begin
         case (name[3:0])
            4'd1: begin
               rec.item_kind    = KIND_VERSION;
               rec.first_value  = {28'h0, body[0][7:4]};
               rec.second_value = {28'h0, body[0][3:0]};
            end
            4'd2, 4'd3: begin
               rec.item_kind    = (name[3:0] == 4'd2) ? KIND_LOGICAL_ID : KIND_COMPAT_ID;
               rec.first_value  = {8'h00, letter(packed_id[14:10]),
                                   letter(packed_id[9:5]), letter(packed_id[4:0])};
               rec.second_value = {16'h0, body[2], body[3]};
            end
            4'd4: begin
               rec.item_kind   = KIND_IRQ;
               rec.first_value = {16'h0, body[1], body[0]};
            end
            4'd5: begin
               rec.item_kind   = KIND_DMA;
               rec.first_value = {24'h0, body[0]};
            end
            4'd8: begin
               rec.item_kind       = KIND_IO;
               rec.full_decode     = body[0][0];
               rec.first_value     = {16'h0, body[2], body[1]};
               rec.second_value    = {16'h0, body[4], body[3]};
               rec.io_alignment    = body[5];
               rec.io_range_length = body[6];
            end
            4'd9:    rec.item_kind = KIND_FIXED_IO;
            4'd14:   rec.item_kind = KIND_VENDOR_SMALL;
            4'd15:   rec.item_kind = KIND_END;
            default: rec.item_kind = KIND_RSVD_SMALL;
         endcase
      end else begin
         case (name)
            7'd1: rec.item_kind = KIND_MEM24;
            7'd2: rec.item_kind = KIND_ANSI;
            7'd3: rec.item_kind = KIND_UNICODE;
            7'd4: rec.item_kind = KIND_VENDOR_LARGE;
            7'd5: rec.item_kind = KIND_MEM32;
            7'd6: begin
               rec.item_kind    = KIND_FIXED_MEM32;
               rec.first_value  = start;
               rec.second_value = start + size - 32'd1;
            end
            default: rec.item_kind = KIND_RSVD_LARGE;
         endcase
      end
      return rec;
   endfunction

endpackage

`default_nettype wire

/* rtl/pnp_resource_descriptor_parser.sv */
// Resource descriptor parser top level: byte-wise tag/length parse, body capture, record out.
// Depends on pnp_rdp_pkg for phase and kind codes and the record decode.
// A record is registered and appears on rsp in the cycle after the byte that ends its item is accepted.
// Throughput: one byte per cycle unless a record waits on rsp with rsp_tready low; the parse
// state and record decode are combinational between the parse and output registers.
// Reset: synchronous, active high; parser waits for a tag byte, no record pending.
`default_nettype none

module pnp_resource_descriptor_parser
   import pnp_rdp_pkg::*;
#(
   parameter int CAPTURE_BYTES = CAPTURE_BYTES_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] data_byte
   input  wire logic         req_tuser,   // [0] first_byte
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [103:0]      rsp_tdata,   // [31:0] first_value, [63:32] second_value,
                                          // [71:64] io_alignment, [79:72] io_range_length,
                                          // [80] full_decode, [96:81] body_length, rest 0
   output logic [4:0]        rsp_tuser    // [4:0] item_kind
);

   localparam int POS_W = $clog2(CAPTURE_BYTES + 1);

   phase_type        phase_ff, phase_in, phase_cur;
   logic             large_ff, large_in;
   logic [6:0]       name_ff, name_in;
   logic [15:0]      left_ff, left_in;
   logic [15:0]      length_ff, length_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       body_ff [CAPTURE_BYTES];
   logic             clear_body, write_body, emit;
   logic             req_fire;
   logic [7:0]       data_byte;
   body_type         body_view;
   record_type       record_in, record_ff;
   logic             rsp_valid_ff;

   assign data_byte  = req_tdata;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign phase_cur  = req_tuser ? PH_TAG : phase_ff;

   always_comb begin
      phase_in   = phase_cur;
      large_in   = large_ff;
      name_in    = name_ff;
      left_in    = left_ff;
      length_in  = length_ff;
      pos_in     = pos_ff;
      clear_body = 1'b0;
      write_body = 1'b0;
      emit       = 1'b0;
      case (phase_cur)
         PH_TAG: begin
            clear_body = 1'b1;
            pos_in     = '0;
            if (data_byte[7]) begin
               large_in = 1'b1;
               name_in  = data_byte[6:0];
               phase_in = PH_LEN_LO;
            end else begin
               large_in  = 1'b0;
               name_in   = {3'b000, data_byte[6:3]};
               length_in = {13'h0, data_byte[2:0]};
               left_in   = {13'h0, data_byte[2:0]};
               if (data_byte[2:0] == 3'd0) begin
                  emit = 1'b1;
               end else begin
                  phase_in = PH_BODY;
               end
            end
         end
         PH_LEN_LO: begin
            length_in = {8'h00, data_byte};
            phase_in  = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            length_in = {data_byte, length_ff[7:0]};
            left_in   = {data_byte, length_ff[7:0]};
            if (left_in == 16'h0) begin
               emit = 1'b1;
            end else begin
               phase_in = PH_BODY;
            end
         end
         PH_BODY: begin
            if (pos_ff < POS_W'(CAPTURE_BYTES)) begin
               write_body = 1'b1;
               pos_in     = pos_ff + POS_W'(1);
            end
            left_in = left_ff - 16'd1;
            if (left_in == 16'h0) begin
               emit = 1'b1;
            end
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_TAG;
         end
      endcase
      if (emit) begin
         phase_in = (!large_in && name_in == SMALL_END_NAME) ? PH_DONE : PH_TAG;
      end
   end

   always_comb begin
      for (int i = 0; i < DECODE_BYTES; i++) begin
         if (clear_body) begin
            body_view[i] = 8'h00;
         end else if (write_body && pos_ff == POS_W'(i)) begin
            body_view[i] = data_byte;
         end else begin
            body_view[i] = body_ff[i];
         end
      end
      record_in = decode_record(large_in, name_in, body_view, length_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TAG;
         large_ff  <= 1'b0;
         name_ff   <= '0;
         left_ff   <= '0;
         length_ff <= '0;
         pos_ff    <= '0;
      end else if (req_fire) begin
         phase_ff  <= phase_in;
         large_ff  <= large_in;
         name_ff   <= name_in;
         left_ff   <= left_in;
         length_ff <= length_in;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < CAPTURE_BYTES; i++) begin
            if (clear_body) begin
               body_ff[i] <= 8'h00;
            end else if (write_body && pos_ff == POS_W'(i)) begin
               body_ff[i] <= data_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         record_ff <= record_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = record_ff.item_kind;
   assign rsp_tdata  = {7'h00, record_ff.body_length, record_ff.full_decode,
                        record_ff.io_range_length, record_ff.io_alignment,
                        record_ff.second_value, record_ff.first_value};

endmodule

`default_nettype wire
